// ----- rtl/core/uwa_pkg.sv -----
// Shared types and constants for the uptime counter with wakeup alarm.
package uwa_pkg;

	// Timer constants
	localparam int PRESCALE        = 100;
	localparam int WAKE_MAX_PERIOD = 65536;
	localparam int PRESCALE_W      = (PRESCALE > 2) ? $clog2(PRESCALE) : 1;

	// Field and counter widths
	localparam int KIND_W   = 2;
	localparam int UPTIME_W = 64;
	localparam int TARGET_W = 55;
	localparam int WAKE_W   = 16;
	localparam int PERIOD_W = 17;

	// Running quotients of the uptime: floor(now/100) and floor(now/1000)
	localparam int US_PER_CENTI = 100;
	localparam int CENTI_PER_MS = 10;
	localparam int REM100_W     = 7;
	localparam int DIG10_W      = 4;
	localparam int Q100_W       = 58;
	localparam int Q1000_W      = 55;
	localparam int T10_W        = 59;

	// Period used when the target is not in the future
	localparam int PERIOD_PAST = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK  = 2'd0,
		KIND_SCHED = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [TARGET_W-1:0] target_ms;
	} in_item_t;

	typedef struct packed {
		logic [UPTIME_W-1:0] uptime_us;
		logic                wakeup_fired;
		logic                wakeup_armed;
		logic [PERIOD_W-1:0] loaded_period;
	} out_item_t;

	// Timebase state seen by the period logic and the top level
	typedef struct packed {
		logic [UPTIME_W-1:0] uptime;
		logic [Q100_W-1:0]   q100;
		logic [Q1000_W-1:0]  q1000;
	} timebase_t;

endpackage

// ----- rtl/core/uwa_timebase.sv -----
// Microsecond uptime counter with cascaded 1/100 and 1/1000 running counts.
module uwa_timebase (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick,
	output uwa_pkg::timebase_t   tb
);

	logic [uwa_pkg::UPTIME_W-1:0] uptime_q;
	logic [uwa_pkg::REM100_W-1:0] rem100_q;
	logic [uwa_pkg::DIG10_W-1:0]  dig10_q;
	logic [uwa_pkg::Q100_W-1:0]   q100_q;
	logic [uwa_pkg::Q1000_W-1:0]  q1000_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uptime_q <= '0;
			rem100_q <= '0;
			dig10_q  <= '0;
			q100_q   <= '0;
			q1000_q  <= '0;
		end else if (tick) begin
			uptime_q <= uptime_q + uwa_pkg::UPTIME_W'(1);
			if (&uptime_q) begin
				// wrap to zero: restart all quotients with it
				rem100_q <= '0;
				dig10_q  <= '0;
				q100_q   <= '0;
				q1000_q  <= '0;
			end else if (rem100_q == uwa_pkg::REM100_W'(uwa_pkg::US_PER_CENTI - 1)) begin
				rem100_q <= '0;
				q100_q   <= q100_q + uwa_pkg::Q100_W'(1);
				if (dig10_q == uwa_pkg::DIG10_W'(uwa_pkg::CENTI_PER_MS - 1)) begin
					dig10_q <= '0;
					q1000_q <= q1000_q + uwa_pkg::Q1000_W'(1);
				end else begin
					dig10_q <= dig10_q + uwa_pkg::DIG10_W'(1);
				end
			end else begin
				rem100_q <= rem100_q + uwa_pkg::REM100_W'(1);
			end
		end
	end

	assign tb.uptime = uptime_q;
	assign tb.q100   = q100_q;
	assign tb.q1000  = q1000_q;

endmodule

// ----- rtl/core/uwa_period.sv -----
// Wakeup period from a millisecond target and the current timebase.
module uwa_period (
	input  logic [uwa_pkg::TARGET_W-1:0] target_ms,
	input  uwa_pkg::timebase_t           tb,
	output logic [uwa_pkg::PERIOD_W-1:0] period
);

	logic [uwa_pkg::T10_W-1:0] t10;
	logic [uwa_pkg::T10_W-1:0] diff;
	logic [uwa_pkg::T10_W-1:0] raw;
	logic                      ahead;

	always_comb begin
		// target*10 as 8x + 2x
		t10   = {1'b0, target_ms, 3'b000} + {3'b000, target_ms, 1'b0};
		diff  = t10 - {1'b0, tb.q100};
		ahead = tb.q1000 < target_ms;
		raw   = ahead ? diff : uwa_pkg::T10_W'(uwa_pkg::PERIOD_PAST);
		if (raw > uwa_pkg::T10_W'(uwa_pkg::WAKE_MAX_PERIOD)) begin
			period = uwa_pkg::PERIOD_W'(uwa_pkg::WAKE_MAX_PERIOD);
		end else begin
			period = raw[uwa_pkg::PERIOD_W-1:0];
		end
	end

endmodule

// ----- rtl/core/uptime_counter_with_wakeup_alarm.sv -----
// Top level: uptime counter with a one-shot prescaled wakeup alarm.
//
//  chan | handshake           | payload
//  -----+---------------------+-----------------------------------------------------------
//  in   | in_valid/in_ready   | in_data: kind, target_ms
//  out  | out_valid/out_ready | out_data: uptime_us, wakeup_fired, wakeup_armed, loaded_period
//
// One beat in gives one beat out: a beat waits in the input register, is resolved in one
// pass against the timer state and lands in the output register.
// One beat per cycle sustained while the output is not stalled; the schedule path (59-bit
// target*10 minus floor(now/100), then the clamp compare) sets the cycle.
// Reset is asynchronous and needs no sweep; the block takes a beat right after.
// A stalled output holds its beat; the input register takes one more beat, then stops.
module uptime_counter_with_wakeup_alarm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  uwa_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output uwa_pkg::out_item_t out_data
);

	// Input register
	logic              valid_s1;
	uwa_pkg::in_item_t item_s1;

	// Output register
	logic               out_valid_q;
	uwa_pkg::out_item_t out_data_q;

	// Wakeup timer state
	logic [uwa_pkg::PRESCALE_W-1:0] prescale_q;
	logic [uwa_pkg::WAKE_W-1:0]     wake_count_q;
	logic [uwa_pkg::WAKE_W-1:0]     wake_reload_q;
	logic                           wake_armed_q;
	logic [uwa_pkg::PERIOD_W-1:0]   last_period_q;

	// Next-state and result signals
	logic                           adv;
	logic                           is_tick;
	logic                           is_sched;
	logic                           slow_tick;
	logic                           fire;
	logic [uwa_pkg::PRESCALE_W-1:0] prescale_d;
	logic [uwa_pkg::WAKE_W-1:0]     wake_count_d;
	logic [uwa_pkg::WAKE_W-1:0]     wake_reload_d;
	logic                           wake_armed_d;
	logic [uwa_pkg::PERIOD_W-1:0]   last_period_d;
	logic [uwa_pkg::PERIOD_W-1:0]   reload_full;
	logic [uwa_pkg::PERIOD_W-1:0]   period;
	logic [uwa_pkg::UPTIME_W-1:0]   uptime_after;
	uwa_pkg::timebase_t             tb;
	uwa_pkg::out_item_t             result;

	// Handshake: process the held beat when the output slot is free or drains
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// Timebase advances on tick beats only
	uwa_timebase u_timebase (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (adv && is_tick),
		.tb     (tb)
	);

	uwa_period u_period (
		.target_ms (item_s1.target_ms),
		.tb        (tb),
		.period    (period)
	);

	always_comb begin
		is_tick  = 1'b0;
		is_sched = 1'b0;
		unique case (item_s1.kind)
			uwa_pkg::KIND_TICK:  is_tick  = 1'b1;
			uwa_pkg::KIND_SCHED: is_sched = 1'b1;
			uwa_pkg::KIND_READ:  ;
			default:             ;   // unused code reads like KIND_READ
		endcase
	end

	always_comb begin
		prescale_d    = prescale_q;
		wake_count_d  = wake_count_q;
		wake_reload_d = wake_reload_q;
		wake_armed_d  = wake_armed_q;
		last_period_d = last_period_q;
		reload_full   = period - uwa_pkg::PERIOD_W'(1);
		slow_tick     = 1'b0;
		fire          = 1'b0;

		if (is_tick) begin
			// free-running prescaler: one slow tick per PRESCALE microseconds
			if (prescale_q == uwa_pkg::PRESCALE_W'(uwa_pkg::PRESCALE - 1)) begin
				prescale_d = '0;
				slow_tick  = 1'b1;
			end else begin
				prescale_d = prescale_q + uwa_pkg::PRESCALE_W'(1);
			end
			if (slow_tick && wake_armed_q) begin
				if (wake_count_q == wake_reload_q) begin
					fire         = 1'b1;
					wake_count_d = '0;
					wake_armed_d = 1'b0;
				end else begin
					wake_count_d = wake_count_q + uwa_pkg::WAKE_W'(1);
				end
			end
		end else if (is_sched) begin
			// reschedule restarts from zero and drops any pending fire
			wake_reload_d = reload_full[uwa_pkg::WAKE_W-1:0];
			wake_count_d  = '0;
			wake_armed_d  = 1'b1;
			last_period_d = period;
		end

		uptime_after = is_tick ? tb.uptime + uwa_pkg::UPTIME_W'(1) : tb.uptime;

		result.uptime_us     = uptime_after;
		result.wakeup_fired  = fire;
		result.wakeup_armed  = wake_armed_d;
		result.loaded_period = last_period_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q    <= '0;
			wake_count_q  <= '0;
			wake_reload_q <= '0;
			wake_armed_q  <= 1'b0;
			last_period_q <= uwa_pkg::PERIOD_W'(1);
		end else if (adv) begin
			prescale_q    <= prescale_d;
			wake_count_q  <= wake_count_d;
			wake_reload_q <= wake_reload_d;
			wake_armed_q  <= wake_armed_d;
			last_period_q <= last_period_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// The timer counter never passes its reload value
	assert property (@(posedge clk) disable iff (!arst_n)
		wake_count_q <= wake_reload_q)
		else $error("wake counter above reload");

	// Prescaler stays inside its modulus
	assert property (@(posedge clk) disable iff (!arst_n)
		prescale_q <= uwa_pkg::PRESCALE_W'(uwa_pkg::PRESCALE - 1))
		else $error("prescaler out of range");

	// A processed tick beat moves the uptime by exactly one
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && is_tick |=> tb.uptime == $past(tb.uptime) + uwa_pkg::UPTIME_W'(1))
		else $error("uptime did not advance on tick");

	// Loaded period is always within 1..WAKE_MAX_PERIOD
	assert property (@(posedge clk) disable iff (!arst_n)
		last_period_q != '0 &&
		last_period_q <= uwa_pkg::PERIOD_W'(uwa_pkg::WAKE_MAX_PERIOD))
		else $error("loaded period out of range");

endmodule
